// ----- rtl/text_mode_console_writer_macros.svh -----
// Assertion macros shared by the console writer RTL.
`ifndef TEXT_MODE_CONSOLE_WRITER_MACROS_SVH
`define TEXT_MODE_CONSOLE_WRITER_MACROS_SVH

`ifndef SYNTHESIS

// Check a condition on every clock edge outside reset.
`define TMCW_ASSERT_ALWAYS(lbl, clk_s, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger implies a consequence on the next clock edge.
`define TMCW_ASSERT_NEXT(lbl, clk_s, rst_n, trig, conseq, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (trig) |=> (conseq)) \
		else $error(msg);

`else

`define TMCW_ASSERT_ALWAYS(lbl, clk_s, rst_n, cond, msg)
`define TMCW_ASSERT_NEXT(lbl, clk_s, rst_n, trig, conseq, msg)

`endif

`endif

// ----- rtl/tmcw_pkg.sv -----
`timescale 1ns / 1ps

package tmcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam int OP_W   = 2;
	localparam int CHAR_W = 8;
	localparam int IDX_W  = 11;
	localparam int POS_W  = 11;
	localparam int ATTR_W = 8;
	localparam int CELL_W = ATTR_W + CHAR_W;

	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;
	localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;

	localparam int TAB_STEP = 4;

	typedef enum logic [OP_W-1:0] {
		OP_PUT   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCROLL,
		ST_BLANK,
		ST_EMIT
	} state_t;

endpackage

// ----- rtl/tmcw_if.sv -----
`timescale 1ns / 1ps

interface tmcw_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [tmcw_pkg::OP_W-1:0]   operation;
	logic [tmcw_pkg::CHAR_W-1:0] char_code;
	logic [tmcw_pkg::IDX_W-1:0]  cell_index;

	modport source (output valid, output operation, output char_code, output cell_index,
		input ready);
	modport sink (input valid, input operation, input char_code, input cell_index,
		output ready);
endinterface

interface tmcw_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [tmcw_pkg::POS_W-1:0]  cursor_position;
	logic [tmcw_pkg::CELL_W-1:0] cell_data;

	modport source (output valid, output cursor_position, output cell_data, input ready);
	modport sink (input valid, input cursor_position, input cell_data, output ready);
endinterface

// ----- rtl/tmcw_ram.sv -----
`timescale 1ns / 1ps

module tmcw_ram #(
	parameter int WIDTH = tmcw_pkg::CELL_W,
	parameter int DEPTH = tmcw_pkg::COLUMNS_DEF * tmcw_pkg::ROWS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// hold read data between reads
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/text_mode_console_writer.sv -----
// Put, read and no-op words: the result is registered on leaving the emit state; a new word is taken only after that.
// Clear: walks every cell through the screen RAM write port.
// Scroll: one RAM read and one write per cell moved.
// Reset: asynchronous, active low; afterwards a zeroing pass over every cell
// runs with cmd.ready low, attribute writes are taken throughout.
`timescale 1ns / 1ps

module text_mode_console_writer #(
	parameter int COLUMNS = tmcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tmcw_pkg::ROWS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [tmcw_pkg::ATTR_W-1:0] cfg_wr_data,
	tmcw_cmd_if.sink                    cmd,
	tmcw_rsp_if.source                  rsp
);

	`include "text_mode_console_writer_macros.svh"

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int SCROLL_N   = (ROWS - 1) * COLUMNS;
	localparam int AW         = $clog2(CELL_COUNT);
	localparam int CBW        = $clog2(COLUMNS);
	localparam int CNW        = $clog2(COLUMNS + tmcw_pkg::TAB_STEP);
	localparam int RBW        = $clog2(ROWS);

	tmcw_pkg::state_t state_q, state_n;

	logic [tmcw_pkg::ATTR_W-1:0] attr_q;
	logic [CBW-1:0]              col_q;
	logic [RBW-1:0]              row_q;
	logic [AW-1:0]               cnt_q;
	logic                        rd_op_q;
	logic                        rd_ok_q;
	logic                        out_v_q;
	logic [tmcw_pkg::POS_W-1:0]  out_pos_q;
	logic [tmcw_pkg::CELL_W-1:0] out_data_q;

	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [tmcw_pkg::CELL_W-1:0] ram_wdata;
	logic                        ram_re;
	logic [AW-1:0]               ram_raddr;
	logic [tmcw_pkg::CELL_W-1:0] ram_rdata;

	logic                        accept;
	tmcw_pkg::op_t               op;
	logic [AW-1:0]               cur_addr;
	logic [CNW-1:0]              col_ext;
	logic [CNW-1:0]              col_step;
	logic                        printable;
	logic                        row_inc;
	logic [CBW-1:0]              col_n;
	logic                        need_scroll;
	logic                        idx_ok;
	logic                        emit_go;
	logic [tmcw_pkg::CELL_W-1:0] blank_cell;

	assign op         = tmcw_pkg::op_t'(cmd.operation);
	assign accept     = cmd.valid && cmd.ready;
	assign cur_addr   = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
	assign blank_cell = {attr_q, tmcw_pkg::BLANK_CHAR};
	assign idx_ok     = 32'(cmd.cell_index) < CELL_COUNT;
	assign emit_go    = !out_v_q || rsp.ready;

	// cursor motion for a put word
	always_comb begin
		col_ext   = CNW'(col_q);
		col_step  = col_ext;
		printable = 1'b0;
		row_inc   = 1'b0;
		case (cmd.char_code)
			tmcw_pkg::CHAR_BS: begin
				if (col_ext != '0) begin
					col_step = col_ext - CNW'(1);
				end
			end
			tmcw_pkg::CHAR_TAB: begin
				col_step = (col_ext + CNW'(tmcw_pkg::TAB_STEP))
					& ~CNW'(tmcw_pkg::TAB_STEP - 1);
			end
			tmcw_pkg::CHAR_CR: begin
				col_step = '0;
			end
			tmcw_pkg::CHAR_LF: begin
				col_step = '0;
				row_inc  = 1'b1;
			end
			default: begin
				printable = 1'b1;
				col_step  = col_ext + CNW'(1);
			end
		endcase
		col_n = CBW'(col_step);
		if (col_step >= CNW'(COLUMNS)) begin
			col_n   = '0;
			row_inc = 1'b1;
		end
		need_scroll = row_inc && (row_q == RBW'(ROWS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tmcw_pkg::ST_INIT;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n   = state_q;
		cmd.ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = blank_cell;
		ram_re    = 1'b0;
		ram_raddr = cnt_q + AW'(COLUMNS);
		case (state_q)
			tmcw_pkg::ST_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = '0;
				if (cnt_q == AW'(CELL_COUNT - 1)) begin
					state_n = tmcw_pkg::ST_IDLE;
				end
			end
			tmcw_pkg::ST_IDLE: begin
				cmd.ready = 1'b1;
				ram_waddr = cur_addr;
				ram_wdata = {attr_q, cmd.char_code};
				ram_raddr = idx_ok ? AW'(cmd.cell_index) : '0;
				if (cmd.valid) begin
					case (op)
						tmcw_pkg::OP_PUT: begin
							ram_we  = printable;
							state_n = need_scroll ? tmcw_pkg::ST_SCROLL
								: tmcw_pkg::ST_EMIT;
						end
						tmcw_pkg::OP_CLEAR: begin
							state_n = tmcw_pkg::ST_BLANK;
						end
						tmcw_pkg::OP_READ: begin
							ram_re  = 1'b1;
							state_n = tmcw_pkg::ST_EMIT;
						end
						default: begin
							state_n = tmcw_pkg::ST_EMIT;
						end
					endcase
				end
			end
			tmcw_pkg::ST_SCROLL: begin
				// read one row ahead, write back the cell read last cycle
				ram_re    = cnt_q != AW'(SCROLL_N);
				ram_we    = cnt_q != '0;
				ram_waddr = cnt_q - AW'(1);
				ram_wdata = ram_rdata;
				if (cnt_q == AW'(SCROLL_N)) begin
					state_n = tmcw_pkg::ST_BLANK;
				end
			end
			tmcw_pkg::ST_BLANK: begin
				ram_we = 1'b1;
				if (cnt_q == AW'(CELL_COUNT - 1)) begin
					state_n = tmcw_pkg::ST_EMIT;
				end
			end
			tmcw_pkg::ST_EMIT: begin
				if (emit_go) begin
					state_n = tmcw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = tmcw_pkg::ST_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q  <= tmcw_pkg::ATTR_RESET;
			col_q   <= '0;
			row_q   <= '0;
			cnt_q   <= '0;
			rd_op_q <= 1'b0;
			rd_ok_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				attr_q <= cfg_wr_data;
			end
			if (state_q == tmcw_pkg::ST_EMIT && emit_go) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				tmcw_pkg::ST_INIT, tmcw_pkg::ST_BLANK: begin
					cnt_q <= cnt_q + AW'(1);
				end
				tmcw_pkg::ST_SCROLL: begin
					// hand over to blanking with the count at the last row
					if (cnt_q != AW'(SCROLL_N)) begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				tmcw_pkg::ST_IDLE: begin
					if (accept) begin
						rd_op_q <= op == tmcw_pkg::OP_READ;
						rd_ok_q <= idx_ok;
						cnt_q   <= '0;
						case (op)
							tmcw_pkg::OP_PUT: begin
								col_q <= col_n;
								if (row_inc && !need_scroll) begin
									row_q <= row_q + RBW'(1);
								end
							end
							tmcw_pkg::OP_CLEAR: begin
								col_q <= '0;
								row_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tmcw_pkg::ST_EMIT && emit_go) begin
			out_pos_q  <= tmcw_pkg::POS_W'(cur_addr);
			out_data_q <= (rd_op_q && rd_ok_q) ? ram_rdata : '0;
		end
	end

	assign rsp.valid           = out_v_q;
	assign rsp.cursor_position = out_pos_q;
	assign rsp.cell_data       = out_data_q;

	tmcw_ram #(
		.WIDTH(tmcw_pkg::CELL_W),
		.DEPTH(CELL_COUNT)
	) u_screen (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	`TMCW_ASSERT_ALWAYS(a_cursor_in_screen, clk, arst_n, (32'(col_q) < COLUMNS) && (32'(row_q) < ROWS), "cursor outside screen")
	`TMCW_ASSERT_ALWAYS(a_write_in_range, clk, arst_n, !ram_we || (32'(ram_waddr) < CELL_COUNT), "screen write out of range")
	`TMCW_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, accept, state_q != tmcw_pkg::ST_IDLE, "accepted word did not start work")

endmodule

// ----- bench/tmcw_console_check.sv -----
`timescale 1ns / 1ps

module tmcw_console_check (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [tmcw_pkg::ATTR_W-1:0] cfg_wr_data,
	tmcw_cmd_if                         cmd,
	tmcw_rsp_if                         rsp,
	output int                          n_fail,
	output int                          n_pending,
	output int                          n_words,
	output int                          n_reads,
	output int                          n_clears,
	output int                          n_scrolls
);
	import tmcw_pkg::*;

	localparam int COLS  = COLUMNS_DEF;
	localparam int NROWS = ROWS_DEF;
	localparam int CELLS = COLS * NROWS;

	typedef struct packed {
		logic [POS_W-1:0]  pos;
		logic [CELL_W-1:0] data;
	} console_rsp_t;

	logic [CELL_W-1:0] cells [CELLS];
	logic [6:0]        col_q;
	logic [4:0]        row_q;
	logic [ATTR_W-1:0] attr_q;
	console_rsp_t      expected_rsp [$];
	int                fails;
	int                words;
	int                reads;
	int                clears;
	int                scrolls;
	int                results_seen;

	function automatic void scroll_screen();
		for (int i = 0; i < CELLS - COLS; i++)
			cells[i] = cells[i + COLS];
		for (int i = CELLS - COLS; i < CELLS; i++)
			cells[i] = {attr_q, BLANK_CHAR};
		scrolls++;
	endfunction

	function automatic void console_put(logic [CHAR_W-1:0] ch);
		int col;
		int row;
		col = col_q;
		row = row_q;
		if (ch == CHAR_BS) begin
			if (col != 0)
				col--;
		end else if (ch == CHAR_TAB) begin
			col = (col + TAB_STEP) & ~(TAB_STEP - 1);
		end else if (ch == CHAR_CR) begin
			col = 0;
		end else if (ch == CHAR_LF) begin
			col = 0;
			row++;
		end else begin
			cells[row * COLS + col] = {attr_q, ch};
			col++;
		end
		if (col >= COLS) begin
			col = 0;
			row++;
		end
		if (row >= NROWS) begin
			scroll_screen();
			row = NROWS - 1;
		end
		col_q = col[6:0];
		row_q = row[4:0];
	endfunction

	function automatic void console_clear();
		for (int i = 0; i < CELLS; i++)
			cells[i] = {attr_q, BLANK_CHAR};
		col_q = '0;
		row_q = '0;
		clears++;
	endfunction

	function automatic console_rsp_t predict_word(op_t op, logic [CHAR_W-1:0] ch,
		logic [IDX_W-1:0] idx);
		console_rsp_t r;
		r.data = '0;
		case (op)
			OP_PUT: console_put(ch);
			OP_CLEAR: console_clear();
			OP_READ: begin
				if (idx < CELLS)
					r.data = cells[idx];
				reads++;
			end
			default: ;
		endcase
		r.pos = POS_W'(row_q * COLS + col_q);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		console_rsp_t exp_w;
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++)
				cells[i] = '0;
			col_q = '0;
			row_q = '0;
			attr_q = ATTR_RESET;
			expected_rsp.delete();
			fails = 0;
			words = 0;
			reads = 0;
			clears = 0;
			scrolls = 0;
			results_seen = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				results_seen++;
				if (expected_rsp.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("result %0d: unexpected word, cursor %0d cell %h",
							results_seen, rsp.cursor_position, rsp.cell_data);
				end else begin
					exp_w = expected_rsp.pop_front();
					if (rsp.cursor_position !== exp_w.pos || rsp.cell_data !== exp_w.data) begin
						fails++;
						if (fails <= 10)
							$display("result %0d: cursor exp %0d got %0d, cell exp %h got %h",
								results_seen, exp_w.pos, rsp.cursor_position,
								exp_w.data, rsp.cell_data);
					end
				end
			end
			if (cfg_wr_en)
				attr_q = cfg_wr_data;
			if (cmd.valid && cmd.ready) begin
				words++;
				expected_rsp.push_back(predict_word(op_t'(cmd.operation), cmd.char_code,
					cmd.cell_index));
			end
		end
		n_fail    <= fails;
		n_pending <= expected_rsp.size();
		n_words   <= words;
		n_reads   <= reads;
		n_clears  <= clears;
		n_scrolls <= scrolls;
	end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import tmcw_pkg::*;

	localparam int CELLS       = COLUMNS_DEF * ROWS_DEF;
	localparam int LAST_CELL   = CELLS - 1;
	localparam int BOTTOM_BASE = CELLS - COLUMNS_DEF;
	localparam int IDX_TOP     = (1 << IDX_W) - 1;
	localparam int PHASES      = 5;
	localparam int PHASE_WORDS = 86;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_FIRST  = 120;
	localparam int HOLD_SECOND = 330;

	typedef enum int {
		RX_OPEN,
		RX_PATTERN,
		RX_COIN,
		RX_SPARSE
	} rx_mode_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [ATTR_W-1:0] cfg_wr_data;

	int fail_count;
	int pending;
	int words_done;
	int reads_done;
	int clears_done;
	int scrolls_done;
	int words_sent;
	int burst_left;
	int attr_writes;
	int quiet_cycles = 0;

	tmcw_cmd_if cmd_if ();
	tmcw_rsp_if rsp_if ();

	text_mode_console_writer u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd_if),
		.rsp         (rsp_if)
	);

	tmcw_console_check u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd_if),
		.rsp         (rsp_if),
		.n_fail      (fail_count),
		.n_pending   (pending),
		.n_words     (words_done),
		.n_reads     (reads_done),
		.n_clears    (clears_done),
		.n_scrolls   (scrolls_done)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic send_word(op_t op, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 24) : $urandom_range(0, 4);
			if (gap > 0) begin
				cmd_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 10);
		end
		cmd_if.valid      <= 1'b1;
		cmd_if.operation  <= op;
		cmd_if.char_code  <= ch;
		cmd_if.cell_index <= idx;
		@(posedge clk);
		while (!cmd_if.ready)
			@(posedge clk);
		burst_left--;
		words_sent++;
	endtask

	// Drop valid and hold until every result is back.
	task automatic wait_idle();
		cmd_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_attr(logic [ATTR_W-1:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		attr_writes++;
	endtask

	function automatic logic [CHAR_W-1:0] random_glyph();
		if ($urandom_range(0, 6) == 0)
			return CHAR_W'($urandom);
		return CHAR_W'($urandom_range(32, 126));
	endfunction

	function automatic logic [CHAR_W-1:0] control_code();
		case ($urandom_range(0, 4))
			0, 1: return CHAR_BS;
			2: return CHAR_TAB;
			3: return CHAR_CR;
			default: return CHAR_LF;
		endcase
	endfunction

	// Reads lean toward the bottom row, where new text lands once the screen scrolls.
	function automatic logic [IDX_W-1:0] read_target();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			return IDX_W'($urandom_range(BOTTOM_BASE, LAST_CELL));
		if (pick < 6)
			return IDX_W'($urandom_range(0, IDX_TOP));
		if (pick < 7)
			return IDX_W'($urandom_range(CELLS, IDX_TOP));
		return IDX_W'($urandom_range(0, LAST_CELL));
	endfunction

	task automatic run_sequence();
		int pick;
		int len;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 16);
			repeat (len)
				send_word(OP_PUT, random_glyph(), IDX_W'($urandom));
			if ($urandom_range(0, 3) == 0)
				send_word(OP_PUT, CHAR_CR, IDX_W'($urandom));
			send_word(OP_PUT, CHAR_LF, IDX_W'($urandom));
		end else if (pick < 60) begin
			repeat ($urandom_range(1, 6))
				send_word(OP_PUT, CHAR_LF, IDX_W'($urandom));
		end else if (pick < 80) begin
			repeat ($urandom_range(1, 4))
				send_word(OP_READ, CHAR_W'($urandom), read_target());
		end else if (pick < 92) begin
			repeat ($urandom_range(1, 6))
				send_word(OP_PUT, control_code(), IDX_W'($urandom));
		end else if (pick < 95) begin
			send_word(OP_CLEAR, CHAR_W'($urandom), IDX_W'($urandom));
		end else begin
			send_word(OP_NONE, CHAR_W'($urandom), IDX_W'($urandom));
		end
	endtask

	initial begin : stimulus
		int               phase_start;
		logic [ATTR_W-1:0] attr_val;
		cmd_if.valid      <= 1'b0;
		cmd_if.operation  <= OP_NONE;
		cmd_if.char_code  <= '0;
		cmd_if.cell_index <= '0;
		cfg_wr_en         <= 1'b0;
		cfg_wr_data       <= '0;
		arst_n            <= 1'b0;
		words_sent  = 0;
		burst_left  = 0;
		attr_writes = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_attr(8'hFF);

		send_word(OP_READ, 8'h00, IDX_W'(0));
		send_word(OP_PUT, 8'h41, IDX_W'(IDX_TOP));
		send_word(OP_PUT, 8'hFF, IDX_W'(0));
		send_word(OP_PUT, 8'h00, IDX_W'(0));
		send_word(OP_PUT, 8'h80, IDX_W'(0));
		send_word(OP_READ, 8'h00, IDX_W'(1));
		send_word(OP_PUT, CHAR_BS, IDX_W'(0));
		send_word(OP_PUT, CHAR_CR, IDX_W'(0));
		// backspace at the left edge must not move or write
		send_word(OP_PUT, CHAR_BS, IDX_W'(0));
		send_word(OP_PUT, CHAR_TAB, IDX_W'(0));
		send_word(OP_PUT, CHAR_TAB, IDX_W'(0));
		send_word(OP_READ, 8'hFF, IDX_W'(IDX_TOP));
		send_word(OP_READ, 8'h00, IDX_W'(LAST_CELL));
		send_word(OP_NONE, 8'hFF, IDX_W'(IDX_TOP));
		send_word(OP_PUT, CHAR_LF, IDX_W'(0));
		send_word(OP_READ, 8'h00, IDX_W'(3));
		send_word(OP_CLEAR, 8'h00, IDX_W'(0));
		send_word(OP_READ, 8'h00, IDX_W'(LAST_CELL));
		send_word(OP_READ, 8'h00, IDX_W'(0));

		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			case (p)
				0: attr_val = 8'h00;
				1: attr_val = ATTR_RESET;
				2: attr_val = 8'h80;
				3: attr_val = ATTR_W'($urandom);
				default: attr_val = 8'hFF;
			endcase
			set_attr(attr_val);
			phase_start = words_sent;
			while (words_sent - phase_start < PHASE_WORDS)
				run_sequence();
		end

		wait_idle();
		repeat (16) @(posedge clk);
		$display("covered %0d words: %0d cell reads, %0d clears, %0d scrolls",
			words_done, reads_done, clears_done, scrolls_done);
		$display("attribute written %0d times, %0d mismatches", attr_writes, fail_count);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin : sink_side
		rx_mode_t   mode;
		int         seg;
		int         holds;
		logic [15:0] pat;
		pat   = 16'hB7E5;
		holds = 0;
		rsp_if.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			// Hold off results long enough for the block to back up onto its input.
			if (holds < 2 && words_done >= ((holds == 0) ? HOLD_FIRST : HOLD_SECOND)) begin
				@(posedge clk);
				rsp_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds++;
			end
			seg  = $urandom_range(8, 64);
			mode = rx_mode_t'($urandom_range(0, 3));
			repeat (seg) begin
				@(posedge clk);
				case (mode)
					RX_OPEN: rsp_if.ready <= 1'b1;
					RX_PATTERN: begin
						rsp_if.ready <= pat[0];
						pat = {pat[0], pat[15:1]};
					end
					RX_COIN: rsp_if.ready <= 1'($urandom_range(0, 1));
					default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tmcw_pkg.sv
rtl/tmcw_if.sv
rtl/tmcw_ram.sv
rtl/text_mode_console_writer.sv
bench/tmcw_console_check.sv
bench/tb_top.sv
